>>> hw/rtl/timestamped_history_rewind_macros.svh
// Assertion macros shared by the checker of the rewind history block.
// Depends on nothing; the including scope provides i_clk and i_rst_n.
`ifndef TIMESTAMPED_HISTORY_REWIND_MACROS_SVH
`define TIMESTAMPED_HISTORY_REWIND_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define THR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("thr check failed");

// Next-cycle implication, checked while out of reset.
`define THR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("thr check failed");

// Next-cycle implication that also holds across reset.
`define THR_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("thr check failed");

`endif

>>> hw/rtl/thr_pkg.sv
// Shared types and constants for the timestamped history rewind block.
// Used by every RTL file of the block; depends on nothing.
package thr_pkg;

    localparam int STAMP_W  = 31;
    localparam int ORIGIN_W = 20;
    localparam int BOX_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int DEPTH_RESET = 32;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_UPDATE = 2'd1,
        KIND_QUERY  = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REWIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH      = 2'd1;

    typedef struct packed {
        logic [STAMP_W-1:0]         stamp;
        logic signed [ORIGIN_W-1:0] x;
        logic signed [ORIGIN_W-1:0] y;
        logic signed [ORIGIN_W-1:0] z;
        logic [BOX_W-1:0]           box_low;
        logic [BOX_W-1:0]           box_high;
    } t_record;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_QMETA,
        S_WALK,
        S_DECIDE,
        S_INTERP,
        S_OUT
    } t_state;

endpackage

>>> hw/rtl/thr_interp.sv
// One-axis interpolation unit: a registered multiply, then a 20-step restoring
// divide and a truncate-toward-zero correction. Depends on thr_pkg.
module thr_interp import thr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [ORIGIN_W-1:0] i_p,
    input  logic signed [ORIGIN_W-1:0] i_n,
    input  logic [STAMP_W-1:0]         i_num,
    input  logic [STAMP_W-1:0]         i_den,
    output logic                       o_done,
    output logic signed [ORIGIN_W-1:0] o_val
);
    localparam int PW = ORIGIN_W + STAMP_W;
    localparam int CNT_W = $clog2(ORIGIN_W);

    logic                       r_busy, r_mul, r_fin, r_done, r_neg;
    logic [CNT_W-1:0]           r_cnt;
    logic [ORIGIN_W-1:0]        r_mag, r_q;
    logic [STAMP_W-1:0]         r_num, r_den;
    logic signed [ORIGIN_W-1:0] r_p, r_val;
    logic [PW-1:0]              r_rem;

    logic signed [ORIGIN_W:0]   diff;
    logic [ORIGIN_W:0]          mag;
    logic [PW-1:0]              trial;
    logic                       rnz;
    logic signed [ORIGIN_W+1:0] q_s, sum, res;

    assign diff  = {i_n[ORIGIN_W-1], i_n} - {i_p[ORIGIN_W-1], i_p};
    assign mag   = diff[ORIGIN_W] ? (~diff + 1'b1) : diff;
    assign trial = PW'(r_den) << r_cnt;
    assign rnz   = (r_rem != '0);

    // Floor quotient first, then step toward zero when the exact value is
    // negative and not whole.
    always_comb begin
        if (r_neg) begin
            q_s = -$signed({2'b00, r_q}) - (rnz ? 22'sd1 : 22'sd0);
        end else begin
            q_s = $signed({2'b00, r_q});
        end
        sum = $signed({{2{r_p[ORIGIN_W-1]}}, r_p}) + q_s;
        res = sum + ((sum < 0 && rnz) ? 22'sd1 : 22'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_mul  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_mul  <= 1'b1;
                r_fin  <= 1'b0;
            end else if (r_busy && r_mul) begin
                r_mul <= 1'b0;
            end else if (r_busy && r_fin) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_fin <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= diff[ORIGIN_W];
            r_mag <= mag[ORIGIN_W-1:0];
            r_num <= i_num;
            r_den <= i_den;
            r_p   <= i_p;
        end else if (r_busy && r_mul) begin
            r_rem <= PW'(r_mag) * PW'(r_num);
            r_q   <= '0;
            r_cnt <= CNT_W'(ORIGIN_W - 1);
        end else if (r_busy && r_fin) begin
            r_val <= res[ORIGIN_W-1:0];
        end else if (r_busy) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_q   <= {r_q[ORIGIN_W-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[ORIGIN_W-2:0], 1'b0};
            end
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_val  = r_val;
endmodule

>>> hw/rtl/timestamped_history_rewind.sv
// Top level of the timestamped history rewind block: record and ring memories,
// the control sequencer and three interpolation units. Depends on thr_pkg and thr_interp.
//
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+------------------------
//  command  | i_start, o_busy, i_kind .. i_box_high     | taken when start & !busy
//  result   | o_result_strobe, o_result_client .. boxes | one cycle, no stall
//  config   | i_cfg_valid, o_cfg_ready, index, data     | taken when valid & ready
//
// A clear leaves busy low; an update passes through the update state. A query runs
// the bookkeeping read, one walk step per ring entry walked, the decide state, the
// interpolation if it interpolates, and the output state: the walk is bound by one
// record memory read per cycle and the interpolation by the 20-step divider. Reset
// is synchronous and clears all ring state at once; the result side has no backpressure.
module timestamped_history_rewind import thr_pkg::*; #(
    parameter int NUM_CLIENTS = 64,
    parameter int RING_DEPTH  = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic [1:0]                 i_kind,
    input  logic [5:0]                 i_client,
    input  logic [STAMP_W-1:0]         i_now_time,
    input  logic [STAMP_W-1:0]         i_command_time,
    input  logic signed [ORIGIN_W-1:0] i_origin_x,
    input  logic signed [ORIGIN_W-1:0] i_origin_y,
    input  logic signed [ORIGIN_W-1:0] i_origin_z,
    input  logic [BOX_W-1:0]           i_box_low,
    input  logic [BOX_W-1:0]           i_box_high,
    output logic                       o_result_strobe,
    output logic [5:0]                 o_result_client,
    output logic                       o_rewound,
    output logic signed [ORIGIN_W-1:0] o_past_x,
    output logic signed [ORIGIN_W-1:0] o_past_y,
    output logic signed [ORIGIN_W-1:0] o_past_z,
    output logic [BOX_W-1:0]           o_past_box_low,
    output logic [BOX_W-1:0]           o_past_box_high,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DAT_W-1:0]       i_cfg_data
);
    localparam int CW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int NUM_REC = NUM_CLIENTS * RING_DEPTH;
    localparam int AW = (NUM_REC > 1) ? $clog2(NUM_REC) : 1;
    localparam int DEPTH_INIT = (DEPTH_RESET > RING_DEPTH) ? RING_DEPTH : DEPTH_RESET;
    localparam int TW = STAMP_W + 2;

    t_state r_state, n_state;

    // Configuration.
    logic [CFG_DAT_W-1:0] r_max_rewind;
    logic [FW-1:0]        r_depth;
    logic                 cfg_wr, depth_wr;
    logic [5:0]           cfg_depth_raw;

    // Captured command.
    logic [5:0]                 r_client;
    logic [CW-1:0]              r_cidx;
    logic signed [TW-1:0]       r_target;
    t_record                    r_in_rec;

    // Ring bookkeeping memory: write slot and fill count per client.
    logic [RW+FW-1:0] meta_mem [NUM_CLIENTS];
    logic [RW+FW-1:0] r_meta_q;
    logic             r_meta_v_q;
    logic             r_meta_vld [NUM_CLIENTS];
    logic [RW-1:0]    meta_ws, ws_next;
    logic [FW-1:0]    meta_fill, fill_next;

    // Record memory.
    t_record          rec_mem [NUM_REC];
    t_record          r_rec_q;
    logic             rec_rd, rec_wr;
    logic [RW-1:0]    rd_idx;
    logic [AW-1:0]    rec_rd_addr, rec_wr_addr;

    // Walk.
    logic [RW-1:0]    r_ridx;
    logic [FW-1:0]    r_left;
    logic             r_has_p, r_has_n;
    t_record          r_prec, r_nrec;
    logic             hit, accept, in_range;

    // Interpolation.
    logic             interp_start, all_done;
    logic [2:0]       done_v;
    logic signed [ORIGIN_W-1:0] ix, iy, iz;
    logic [STAMP_W-1:0] num, den;

    // Result.
    logic                       r_res_rew;
    logic signed [ORIGIN_W-1:0] r_res_x, r_res_y, r_res_z;
    logic [BOX_W-1:0]           r_res_bl, r_res_bh;

    logic signed [TW-1:0] now_s, cmd_s, lag, floor_t;

    function automatic logic [RW-1:0] prev_idx(input logic [RW-1:0] x,
                                               input logic [FW-1:0] d);
        logic [RW-1:0] r;
        if (x == '0) begin
            r = RW'(d - 1'b1);
        end else begin
            r = x - 1'b1;
        end
        return r;
    endfunction

    assign in_range = (32'(i_client) < NUM_CLIENTS);
    assign accept   = i_start && !o_busy;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr   = i_cfg_valid && o_cfg_ready;
    assign depth_wr = cfg_wr && (i_cfg_index == CFG_DEPTH);
    assign cfg_depth_raw = i_cfg_data[5:0];

    assign now_s   = $signed({2'b00, i_now_time});
    assign cmd_s   = $signed({2'b00, i_command_time});
    assign lag     = now_s - cmd_s;
    assign floor_t = now_s - $signed({{(TW-CFG_DAT_W){1'b0}}, r_max_rewind});

    assign meta_ws   = r_meta_v_q ? r_meta_q[RW+FW-1:FW] : '0;
    assign meta_fill = r_meta_v_q ? r_meta_q[FW-1:0] : '0;
    assign ws_next   = (32'(meta_ws) + 1 >= 32'(r_depth)) ? '0 : meta_ws + 1'b1;
    assign fill_next = (meta_fill < r_depth) ? meta_fill + 1'b1 : meta_fill;

    assign hit = ($signed({2'b00, r_rec_q.stamp}) <= r_target);

    assign num = STAMP_W'(r_target) - r_prec.stamp;
    assign den = r_nrec.stamp - r_prec.stamp;
    assign all_done = &done_v;

    assign rd_idx      = (r_state == S_QMETA) ? prev_idx(meta_ws, r_depth) : r_ridx;
    assign rec_rd_addr = AW'(32'(r_cidx) * RING_DEPTH + 32'(rd_idx));
    assign rec_wr_addr = AW'(32'(r_cidx) * RING_DEPTH + 32'(meta_ws));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && in_range && i_kind == KIND_UPDATE) begin
                    n_state = S_UPD;
                end else if (accept && in_range && i_kind == KIND_QUERY) begin
                    n_state = S_QMETA;
                end
            end
            S_UPD:   n_state = S_IDLE;
            S_QMETA: n_state = (meta_fill == '0) ? S_DECIDE : S_WALK;
            S_WALK: begin
                if (hit || r_left == '0) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_has_p && r_has_n && r_prec.stamp != r_nrec.stamp) begin
                    n_state = S_INTERP;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_INTERP: begin
                if (all_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_busy          = (r_state != S_IDLE);
        o_result_strobe = (r_state == S_OUT);
        rec_wr          = (r_state == S_UPD);
        rec_rd          = ((r_state == S_QMETA) && meta_fill != '0) ||
                          ((r_state == S_WALK) && !hit && r_left != '0);
        interp_start    = (r_state == S_DECIDE) && (n_state == S_INTERP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_max_rewind <= '0;
            r_depth      <= FW'(DEPTH_INIT);
            for (int i = 0; i < NUM_CLIENTS; i++) begin
                r_meta_vld[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            if (cfg_wr && i_cfg_index == CFG_MAX_REWIND) begin
                r_max_rewind <= i_cfg_data;
            end
            if (depth_wr) begin
                if (cfg_depth_raw == '0) begin
                    r_depth <= FW'(1);
                end else if (32'(cfg_depth_raw) > RING_DEPTH) begin
                    r_depth <= FW'(RING_DEPTH);
                end else begin
                    r_depth <= FW'(cfg_depth_raw);
                end
                for (int i = 0; i < NUM_CLIENTS; i++) begin
                    r_meta_vld[i] <= 1'b0;
                end
            end else if (accept && in_range && i_kind == KIND_CLEAR) begin
                r_meta_vld[CW'(i_client)] <= 1'b0;
            end else if (r_state == S_UPD) begin
                r_meta_vld[r_cidx] <= 1'b1;
            end
        end
    end

    // Command capture, bookkeeping read and bookkeeping write.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_client   <= i_client;
            r_cidx     <= CW'(i_client);
            r_target   <= (lag > $signed({{(TW-CFG_DAT_W){1'b0}}, r_max_rewind})) ?
                          floor_t : cmd_s;
            r_in_rec   <= '{stamp: i_now_time, x: i_origin_x, y: i_origin_y,
                            z: i_origin_z, box_low: i_box_low, box_high: i_box_high};
            r_meta_q   <= meta_mem[CW'(i_client)];
            r_meta_v_q <= r_meta_vld[CW'(i_client)];
        end
        if (r_state == S_UPD) begin
            meta_mem[r_cidx] <= {ws_next, fill_next};
        end
    end

    // Record memory.
    always_ff @(posedge i_clk) begin
        if (rec_wr) begin
            rec_mem[rec_wr_addr] <= r_in_rec;
        end
        if (rec_rd) begin
            r_rec_q <= rec_mem[rec_rd_addr];
        end
    end

    // Walk from newest to oldest; the first stamp at or before the target, or the oldest entry, ends it.
    always_ff @(posedge i_clk) begin
        if (r_state == S_QMETA) begin
            r_has_p <= 1'b0;
            r_has_n <= 1'b0;
            r_ridx  <= prev_idx(prev_idx(meta_ws, r_depth), r_depth);
            r_left  <= meta_fill - 1'b1;
        end else if (r_state == S_WALK) begin
            if (hit) begin
                r_prec  <= r_rec_q;
                r_has_p <= 1'b1;
            end else begin
                r_nrec  <= r_rec_q;
                r_has_n <= 1'b1;
                if (r_left != '0) begin
                    r_ridx <= prev_idx(r_ridx, r_depth);
                    r_left <= r_left - 1'b1;
                end
            end
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE && n_state == S_OUT) begin
            r_res_rew <= r_has_p || r_has_n;
            if (r_has_p) begin
                r_res_x  <= r_prec.x;
                r_res_y  <= r_prec.y;
                r_res_z  <= r_prec.z;
                r_res_bl <= r_prec.box_low;
                r_res_bh <= r_prec.box_high;
            end else if (r_has_n) begin
                r_res_x  <= r_nrec.x;
                r_res_y  <= r_nrec.y;
                r_res_z  <= r_nrec.z;
                r_res_bl <= r_nrec.box_low;
                r_res_bh <= r_nrec.box_high;
            end else begin
                r_res_x  <= '0;
                r_res_y  <= '0;
                r_res_z  <= '0;
                r_res_bl <= '0;
                r_res_bh <= '0;
            end
        end else if (r_state == S_INTERP && all_done) begin
            r_res_rew <= 1'b1;
            r_res_x   <= ix;
            r_res_y   <= iy;
            r_res_z   <= iz;
            r_res_bl  <= r_prec.box_low;
            r_res_bh  <= r_prec.box_high;
        end
    end

    thr_interp u_interp_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(interp_start),
        .i_p(r_prec.x), .i_n(r_nrec.x), .i_num(num), .i_den(den),
        .o_done(done_v[0]), .o_val(ix)
    );
    thr_interp u_interp_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(interp_start),
        .i_p(r_prec.y), .i_n(r_nrec.y), .i_num(num), .i_den(den),
        .o_done(done_v[1]), .o_val(iy)
    );
    thr_interp u_interp_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(interp_start),
        .i_p(r_prec.z), .i_n(r_nrec.z), .i_num(num), .i_den(den),
        .o_done(done_v[2]), .o_val(iz)
    );

    assign o_result_client = r_client;
    assign o_rewound       = r_res_rew;
    assign o_past_x        = r_res_x;
    assign o_past_y        = r_res_y;
    assign o_past_z        = r_res_z;
    assign o_past_box_low  = r_res_bl;
    assign o_past_box_high = r_res_bh;
endmodule

>>> hw/rtl/thr_checker.sv
// Port-level checker for the timestamped history rewind block, with its bind.
// Depends on thr_pkg and timestamped_history_rewind_macros.svh.
`include "timestamped_history_rewind_macros.svh"

module thr_checker import thr_pkg::*; #(
    parameter int NUM_CLIENTS = 64
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_start,
    input logic                       o_busy,
    input logic [1:0]                 i_kind,
    input logic [5:0]                 i_client,
    input logic                       o_result_strobe,
    input logic                       o_rewound,
    input logic signed [ORIGIN_W-1:0] o_past_x,
    input logic [BOX_W-1:0]           o_past_box_low
);
    logic query_go;
    assign query_go = i_start && !o_busy && (i_kind == KIND_QUERY) &&
                      (32'(i_client) < NUM_CLIENTS);

    `THR_ASSERT_NOW(a_strobe_busy, o_result_strobe, o_busy)
    `THR_ASSERT_NEXT(a_query_busy, query_go, o_busy && !o_result_strobe)
    `THR_ASSERT_NEXT(a_single_word, o_result_strobe, !o_result_strobe && !o_busy)
    `THR_ASSERT_NOW(a_zero_miss, o_result_strobe && !o_rewound,
                    o_past_x == '0 && o_past_box_low == '0)
    `THR_ASSERT_RST(a_reset_idle, !i_rst_n, !o_busy && !o_result_strobe)
endmodule

bind timestamped_history_rewind thr_checker #(.NUM_CLIENTS(NUM_CLIENTS)) u_thr_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .i_kind(i_kind), .i_client(i_client), .o_result_strobe(o_result_strobe),
    .o_rewound(o_rewound), .o_past_x(o_past_x), .o_past_box_low(o_past_box_low)
);
